[src/chm_pkg.sv]
// chm_pkg: types and constants shared by the chained hash map.
// No dependencies.
package chm_pkg;

  localparam int BUCKETS_DEF = 1000;
  localparam int POOL_NODES_DEF = 1024;
  localparam int KEY_W = 31;
  localparam int VAL_W = 32;
  localparam int CNT_W = 11;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_SEARCH = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_MISSING = 2'd1,
    ST_FULL    = 2'd2,
    ST_RSVD    = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_MOD,
    S_HEAD_RD,
    S_HEAD_WT,
    S_NODE_WT,
    S_NODE_CHK,
    S_INS_WR,
    S_DEL_WR,
    S_OUT
  } fsm_t;

endpackage

[src/chm_mod.sv]
// chm_mod: key modulo bucket count by reciprocal multiplication.
// Depends on chm_pkg.
module chm_mod
  import chm_pkg::*;
#(
  parameter int BUCKETS = BUCKETS_DEF,
  parameter int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [KEY_W-1:0] key,
  output logic             done,
  output logic [BW-1:0]    bucket
);

  // quotient = (key * MUL) >> SH, exact for every key below 2**KEY_W
  localparam int SH  = KEY_W + BW;
  localparam int MW  = KEY_W + 1;
  localparam int PRW = KEY_W + MW;
  localparam int QDW = KEY_W + BW + 1;
  localparam logic [63:0] MUL_FULL =
    ((64'd1 << SH) + 64'(BUCKETS) - 64'd1) / 64'(BUCKETS);
  localparam logic [MW-1:0] MUL = MW'(MUL_FULL);

  logic [KEY_W-1:0] key_r, key_nxt;
  logic [PRW-1:0]   prod_r, prod_nxt;
  logic [KEY_W-1:0] qd_r, qd_nxt;
  logic [2:0]       stg_r, stg_nxt;
  logic [KEY_W-1:0] quo;
  logic [BW-1:0]    rem;

  always_comb begin
    key_nxt  = key_r;
    prod_nxt = prod_r;
    qd_nxt   = qd_r;
    stg_nxt  = {stg_r[1:0], start};
    quo      = KEY_W'(prod_r >> SH);
    rem      = BW'(key_r - qd_r);
    if (start) begin
      key_nxt = key;
    end
    if (stg_r[0]) begin
      prod_nxt = PRW'(key_r) * PRW'(MUL);
    end
    if (stg_r[1]) begin
      qd_nxt = KEY_W'(QDW'(quo) * QDW'(BUCKETS));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_r <= '0;
    end else begin
      stg_r <= stg_nxt;
    end
    key_r  <= key_nxt;
    prod_r <= prod_nxt;
    qd_r   <= qd_nxt;
  end

  assign done   = stg_r[2];
  assign bucket = rem;

endmodule

[src/chm_core.sv]
// chm_core: bucket-head and node memories with the chain-walk sequencer.
// Depends on chm_pkg and chm_mod.
module chm_core
  import chm_pkg::*;
#(
  parameter int BUCKETS = BUCKETS_DEF,
  parameter int POOL_NODES = POOL_NODES_DEF,
  parameter int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1,
  parameter int NW = $clog2(POOL_NODES + 1)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [1:0]        in_cmd,
  input  logic [KEY_W-1:0]  in_key,
  input  logic [VAL_W-1:0]  in_val,
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [1:0]        out_status,
  output logic [VAL_W-1:0]  out_value,
  output logic [CNT_W-1:0]  out_count
);

  localparam int PW = (POOL_NODES > 1) ? $clog2(POOL_NODES) : 1;
  localparam logic [NW-1:0] NIL = NW'(POOL_NODES);
  localparam int CLR_N = (BUCKETS > POOL_NODES) ? BUCKETS : POOL_NODES;
  localparam int CLW = $clog2(CLR_N + 1);

  // memories
  logic [NW-1:0]    head_mem [BUCKETS];
  logic [KEY_W-1:0] key_mem  [POOL_NODES];
  logic [VAL_W-1:0] val_mem  [POOL_NODES];
  logic [NW-1:0]    link_mem [POOL_NODES];

  logic [NW-1:0]    head_rd_r;
  logic [KEY_W-1:0] key_rd_r;
  logic [VAL_W-1:0] val_rd_r;
  logic [NW-1:0]    link_rd_r;

  fsm_t             st_r, st_nxt;
  logic [1:0]       cmd_r, cmd_nxt;
  logic [KEY_W-1:0] key_r, key_nxt;
  logic [VAL_W-1:0] val_r, val_nxt;
  logic [BW-1:0]    bkt_r, bkt_nxt;
  logic [NW-1:0]    cur_r, cur_nxt;
  logic [NW-1:0]    prv_r, prv_nxt;
  logic [NW-1:0]    free_r, free_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CLW-1:0]   clr_r, clr_nxt;
  logic [1:0]       sts_r, sts_nxt;
  logic [VAL_W-1:0] fv_r, fv_nxt;
  logic             ov_r, ov_nxt;
  logic [1:0]       osts_r, osts_nxt;
  logic [VAL_W-1:0] ofv_r, ofv_nxt;
  logic [CNT_W-1:0] ocnt_r, ocnt_nxt;

  logic             mod_start, mod_done;
  logic [BW-1:0]    mod_bucket;

  logic             h_rd, h_we;
  logic [BW-1:0]    h_addr;
  logic [NW-1:0]    h_wd;
  logic             n_rd, k_we, l_we;
  logic [PW-1:0]    n_raddr, k_waddr, l_waddr;
  logic [NW-1:0]    l_wd;

  chm_mod #(.BUCKETS(BUCKETS), .BW(BW)) u_mod (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (mod_start),
    .key    (key_r),
    .done   (mod_done),
    .bucket (mod_bucket)
  );

  always_ff @(posedge clk) begin
    if (h_we) begin
      head_mem[h_addr] <= h_wd;
    end
    if (h_rd) begin
      head_rd_r <= head_mem[h_addr];
    end
    if (k_we) begin
      key_mem[k_waddr] <= key_r;
      val_mem[k_waddr] <= val_r;
    end
    if (l_we) begin
      link_mem[l_waddr] <= l_wd;
    end
    if (n_rd) begin
      key_rd_r  <= key_mem[n_raddr];
      val_rd_r  <= val_mem[n_raddr];
      link_rd_r <= link_mem[n_raddr];
    end
  end

  always_comb begin
    st_nxt    = st_r;
    cmd_nxt   = cmd_r;
    key_nxt   = key_r;
    val_nxt   = val_r;
    bkt_nxt   = bkt_r;
    cur_nxt   = cur_r;
    prv_nxt   = prv_r;
    free_nxt  = free_r;
    cnt_nxt   = cnt_r;
    clr_nxt   = clr_r;
    sts_nxt   = sts_r;
    fv_nxt    = fv_r;
    ov_nxt    = ov_r;
    osts_nxt  = osts_r;
    ofv_nxt   = ofv_r;
    ocnt_nxt  = ocnt_r;
    mod_start = 1'b0;
    h_rd      = 1'b0;
    h_we      = 1'b0;
    h_addr    = bkt_r;
    h_wd      = NIL;
    n_rd      = 1'b0;
    n_raddr   = cur_r[PW-1:0];
    k_we      = 1'b0;
    k_waddr   = free_r[PW-1:0];
    l_we      = 1'b0;
    l_waddr   = clr_r[PW-1:0];
    l_wd      = NW'(clr_r + 1'b1);
    in_tready = 1'b0;
    if (ov_r && out_tready) begin
      ov_nxt = 1'b0;
    end
    unique case (st_r)
      S_CLEAR: begin
        // one head and one link entry per cycle
        if (clr_r < CLW'(BUCKETS)) begin
          h_we   = 1'b1;
          h_addr = clr_r[BW-1:0];
        end
        if (clr_r < CLW'(POOL_NODES)) begin
          l_we = 1'b1;
        end
        clr_nxt = clr_r + 1'b1;
        if (clr_r == CLW'(CLR_N - 1)) begin
          st_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd_nxt   = in_cmd;
          key_nxt   = in_key;
          val_nxt   = in_val;
          sts_nxt   = ST_OK;
          fv_nxt    = '1;
          if (in_cmd == CMD_NONE) begin
            st_nxt = S_OUT;
          end else if (in_cmd == CMD_INSERT && free_r >= NIL) begin
            sts_nxt = ST_FULL;
            st_nxt  = S_OUT;
          end else begin
            st_nxt = S_MOD;
          end
        end
      end
      S_MOD: begin
        st_nxt    = S_HEAD_RD;
        mod_start = 1'b1;
      end
      S_HEAD_RD: begin
        if (mod_done) begin
          bkt_nxt = mod_bucket;
          h_addr  = mod_bucket;
          h_rd    = 1'b1;
          st_nxt  = S_HEAD_WT;
        end
      end
      S_HEAD_WT: begin
        prv_nxt = NIL;
        cur_nxt = head_rd_r;
        if (cmd_r == CMD_INSERT) begin
          // pop free node, needs its link
          n_rd    = 1'b1;
          n_raddr = free_r[PW-1:0];
          st_nxt  = S_INS_WR;
        end else if (head_rd_r >= NIL) begin
          sts_nxt = ST_MISSING;
          st_nxt  = S_OUT;
        end else begin
          n_rd    = 1'b1;
          n_raddr = head_rd_r[PW-1:0];
          st_nxt  = S_NODE_CHK;
        end
      end
      S_INS_WR: begin
        k_we     = 1'b1;
        l_we     = 1'b1;
        l_waddr  = free_r[PW-1:0];
        l_wd     = cur_r;
        h_we     = 1'b1;
        h_wd     = free_r;
        free_nxt = link_rd_r;
        cnt_nxt  = cnt_r + 1'b1;
        st_nxt   = S_OUT;
      end
      S_NODE_CHK: begin
        if (key_rd_r == key_r) begin
          if (cmd_r == CMD_SEARCH) begin
            fv_nxt = val_rd_r;
            st_nxt = S_OUT;
          end else begin
            st_nxt = S_DEL_WR;
          end
        end else if (link_rd_r >= NIL) begin
          sts_nxt = ST_MISSING;
          st_nxt  = S_OUT;
        end else begin
          prv_nxt = cur_r;
          cur_nxt = link_rd_r;
          n_rd    = 1'b1;
          n_raddr = link_rd_r[PW-1:0];
        end
      end
      S_DEL_WR: begin
        // unlink (head or predecessor), then push on free list
        if (prv_r >= NIL) begin
          h_we = 1'b1;
          h_wd = link_rd_r;
          l_we    = 1'b1;
          l_waddr = cur_r[PW-1:0];
          l_wd    = free_r;
          free_nxt = cur_r;
          if (cnt_r != '0) begin
            cnt_nxt = cnt_r - 1'b1;
          end
          st_nxt = S_OUT;
        end else begin
          l_we    = 1'b1;
          l_waddr = prv_r[PW-1:0];
          l_wd    = link_rd_r;
          prv_nxt = NIL;
          st_nxt  = S_NODE_WT;
        end
      end
      S_NODE_WT: begin
        l_we     = 1'b1;
        l_waddr  = cur_r[PW-1:0];
        l_wd     = free_r;
        free_nxt = cur_r;
        if (cnt_r != '0) begin
          cnt_nxt = cnt_r - 1'b1;
        end
        st_nxt = S_OUT;
      end
      S_OUT: begin
        if (!ov_r || out_tready) begin
          ov_nxt   = 1'b1;
          osts_nxt = sts_r;
          ofv_nxt  = fv_r;
          ocnt_nxt = cnt_r;
          st_nxt   = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= S_CLEAR;
      clr_r  <= '0;
      free_r <= '0;
      cnt_r  <= '0;
      ov_r   <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      clr_r  <= clr_nxt;
      free_r <= free_nxt;
      cnt_r  <= cnt_nxt;
      ov_r   <= ov_nxt;
    end
    cmd_r  <= cmd_nxt;
    key_r  <= key_nxt;
    val_r  <= val_nxt;
    bkt_r  <= bkt_nxt;
    cur_r  <= cur_nxt;
    prv_r  <= prv_nxt;
    sts_r  <= sts_nxt;
    fv_r   <= fv_nxt;
    osts_r <= osts_nxt;
    ofv_r  <= ofv_nxt;
    ocnt_r <= ocnt_nxt;
  end

  assign out_tvalid = ov_r;
  assign out_status = osts_r;
  assign out_value  = ofv_r;
  assign out_count  = ocnt_r;

endmodule

[src/chained_hash_map_top.sv]
// channel | ports          | tdata (low bit up)                         | tuser
// in      | in_t*          | lookup_key[30:0], entry_value[62:31], pad  | cmd[1:0]
// out     | out_t*         | found_value[31:0], element_count[42:32]    | status[1:0]
// Per item: accept, a start state, the key modulo (reciprocal multiply), head read, a check per chain
// node walked by search and delete, write-back (insert: S_INS_WR; delete: S_DEL_WR, plus S_NODE_WT
// when a predecessor is relinked), output. A no-op, or an insert into a full pool, skips to output.
// After reset a clearing pass over max(BUCKETS, POOL_NODES) entries runs before
// the first beat is taken. A result waits in the output register; the next
// beat is taken while it waits and stalls in its output state until it drains.
// Depends on chm_pkg, chm_core, chm_mod.
module chained_hash_map_top
  import chm_pkg::*;
#(
  parameter int BUCKETS = BUCKETS_DEF,
  parameter int POOL_NODES = POOL_NODES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,  // lookup_key, entry_value, zero pad
  input  logic [1:0]  in_tuser,  // cmd
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata, // found_value, element_count, zero pad
  output logic [1:0]  out_tuser  // status
);

  logic [VAL_W-1:0] value;
  logic [CNT_W-1:0] count;

  chm_core #(.BUCKETS(BUCKETS), .POOL_NODES(POOL_NODES)) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_cmd     (in_tuser),
    .in_key     (in_tdata[30:0]),
    .in_val     (in_tdata[62:31]),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_status (out_tuser),
    .out_value  (value),
    .out_count  (count)
  );

  assign out_tdata = {5'd0, count, value};

endmodule

[tb/tb.sv]
// tb: self-checking bench for chained_hash_map_top. It holds its own model of the hash map
// (bucket heads, node pool and free list) and checks every result beat in order.
// Depends on chm_pkg and the RTL of the block.
module tb;
  import chm_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NBKT = BUCKETS_DEF;
  localparam int NPOOL = POOL_NODES_DEF;
  localparam int NIL = NPOOL;
  localparam int STALL_LIMIT = 20000;
  localparam int HOLD_CYCLES = 400;

  typedef struct packed {
    status_t           status;
    logic [VAL_W-1:0]  found;
    logic [CNT_W-1:0]  count;
  } map_result_t;

  typedef struct {
    cmd_t              cmd;
    logic [KEY_W-1:0]  key;
    logic [VAL_W-1:0]  val;
    bit                typed;
    map_result_t       res;
  } op_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [63:0] in_tdata = '0;
  logic [1:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [47:0] out_tdata;
  logic [1:0] out_tuser;

  chained_hash_map_top uut (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .out_tvalid, .out_tready, .out_tdata, .out_tuser
  );

  always #1 clk = ~clk;

  // model state
  int unsigned bkt_head [NBKT];
  logic [KEY_W-1:0] nd_key [NPOOL];
  logic [VAL_W-1:0] nd_val [NPOOL];
  int unsigned nd_next [NPOOL];
  int unsigned free_node;
  int unsigned stored;

  map_result_t pending_q[$];
  int fails = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_req = 0;
  logic [KEY_W-1:0] key_set [48];

  function automatic bit chain_find(int unsigned b, logic [KEY_W-1:0] k,
                                    output int unsigned hit, output int unsigned prv);
    int unsigned cur;
    cur = bkt_head[b];
    prv = NIL;
    hit = NIL;
    for (int s = 0; s < NPOOL; s++) begin
      if (cur >= NIL) return 0;
      if (nd_key[cur] == k) begin
        hit = cur;
        return 1;
      end
      prv = cur;
      cur = nd_next[cur];
    end
    return 0;
  endfunction

  function automatic map_result_t map_apply(cmd_t c, logic [KEY_W-1:0] k, logic [VAL_W-1:0] v);
    map_result_t r;
    int unsigned b, n, hit, prv;
    b = k % NBKT;
    r.status = ST_OK;
    r.found = '1;
    case (c)
      CMD_INSERT: begin
        if (free_node >= NIL) begin
          r.status = ST_FULL;
        end else begin
          n = free_node;
          free_node = nd_next[n];
          nd_key[n] = k;
          nd_val[n] = v;
          nd_next[n] = bkt_head[b];
          bkt_head[b] = n;
          stored++;
        end
      end
      CMD_DELETE: begin
        if (chain_find(b, k, hit, prv)) begin
          if (prv >= NIL) bkt_head[b] = nd_next[hit];
          else nd_next[prv] = nd_next[hit];
          nd_next[hit] = free_node;
          free_node = hit;
          if (stored > 0) stored--;
        end else begin
          r.status = ST_MISSING;
        end
      end
      CMD_SEARCH: begin
        if (chain_find(b, k, hit, prv)) r.found = nd_val[hit];
        else r.status = ST_MISSING;
      end
      default: ;
    endcase
    r.count = stored[CNT_W-1:0];
    return r;
  endfunction

  // one input beat; expectation recorded at the accepting edge
  task automatic send_op(op_row_t row);
    map_result_t r;
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid = 1'b0;
      @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tdata = {1'b0, row.val, row.key};
    in_tuser = row.cmd;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    r = map_apply(row.cmd, row.key, row.val);
    pending_q.push_back(row.typed ? row.res : r);
  endtask

  task automatic idle_input();
    @(negedge clk);
    in_tvalid = 1'b0;
  endtask

  function automatic op_row_t rand_op(int ins_w, int del_w);
    op_row_t row;
    int pick;
    pick = $urandom_range(99);
    if (pick < ins_w) row.cmd = CMD_INSERT;
    else if (pick < ins_w + del_w) row.cmd = CMD_DELETE;
    else if (pick < 95) row.cmd = CMD_SEARCH;
    else row.cmd = CMD_NONE;
    if ($urandom_range(9) == 0) row.key = KEY_W'($urandom());
    else row.key = key_set[$urandom_range(47)];
    row.val = $urandom();
    row.typed = 0;
    row.res = '0;
    return row;
  endfunction

  // receiver: random stalls, plus a long hold-off on request
  int hold_seen = 0;
  int hold_left = 0;
  always @(negedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    map_result_t exp_r;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_q.size() == 0) begin
        $error("result beat with nothing expected");
        fails++;
      end else begin
        exp_r = pending_q.pop_front();
        if (out_tuser !== exp_r.status) begin
          $error("status: expected %0d, got %0d", exp_r.status, out_tuser);
          fails++;
        end
        if (out_tdata[31:0] !== exp_r.found) begin
          $error("found_value: expected %0d, got %0d", $signed(exp_r.found),
                 $signed(out_tdata[31:0]));
          fails++;
        end
        if (out_tdata[42:32] !== exp_r.count) begin
          $error("element_count: expected %0d, got %0d", exp_r.count, out_tdata[42:32]);
          fails++;
        end
      end
    end
  end

  // watchdog on cycles without any beat
  int quiet = 0;
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= STALL_LIMIT) begin
      $display("chained_hash_map_top: mismatch");
      $finish;
    end
  end

  op_row_t dir_tab [$];

  function automatic op_row_t mk(cmd_t c, logic [KEY_W-1:0] k, logic [VAL_W-1:0] v,
                                 bit t = 0, status_t s = ST_OK,
                                 logic [VAL_W-1:0] f = '1, int n = 0);
    op_row_t row;
    row.cmd = c;
    row.key = k;
    row.val = v;
    row.typed = t;
    row.res.status = s;
    row.res.found = f;
    row.res.count = CNT_W'(n);
    return row;
  endfunction

  initial begin
    for (int i = 0; i < NBKT; i++) bkt_head[i] = NIL;
    for (int i = 0; i < NPOOL; i++) begin
      nd_key[i] = '0;
      nd_val[i] = '0;
      nd_next[i] = i + 1;
    end
    free_node = 0;
    stored = 0;
    // few buckets, many collisions
    for (int i = 0; i < 48; i++)
      key_set[i] = KEY_W'($urandom_range(11) + 1000 * $urandom_range(2147482));

    // after reset, extremes, not-found, unused command, then collisions in bucket 0
    dir_tab.push_back(mk(CMD_SEARCH, 31'd0, 32'd5, 1, ST_MISSING, '1, 0));
    dir_tab.push_back(mk(CMD_DELETE, 31'h7fffffff, 32'd0, 1, ST_MISSING, '1, 0));
    dir_tab.push_back(mk(CMD_NONE, 31'd1234, 32'h5555aaaa, 1, ST_OK, '1, 0));
    dir_tab.push_back(mk(CMD_INSERT, 31'd0, 32'h80000000, 1, ST_OK, '1, 1));
    dir_tab.push_back(mk(CMD_INSERT, 31'd1000, 32'h7fffffff, 1, ST_OK, '1, 2));
    dir_tab.push_back(mk(CMD_INSERT, 31'h7fffffff, 32'hffffffff, 1, ST_OK, '1, 3));
    dir_tab.push_back(mk(CMD_INSERT, 31'd2000, 32'd0, 1, ST_OK, '1, 4));
    dir_tab.push_back(mk(CMD_SEARCH, 31'd0, 32'd0));
    dir_tab.push_back(mk(CMD_SEARCH, 31'd1000, 32'd0));
    dir_tab.push_back(mk(CMD_SEARCH, 31'h7fffffff, 32'd0));
    dir_tab.push_back(mk(CMD_SEARCH, 31'd3000, 32'd0));
    dir_tab.push_back(mk(CMD_INSERT, 31'd1000, 32'd77));
    dir_tab.push_back(mk(CMD_SEARCH, 31'd1000, 32'd0));
    dir_tab.push_back(mk(CMD_DELETE, 31'd1000, 32'd0));
    dir_tab.push_back(mk(CMD_SEARCH, 31'd1000, 32'd0));
    dir_tab.push_back(mk(CMD_DELETE, 31'd0, 32'd0));
    dir_tab.push_back(mk(CMD_DELETE, 31'd2000, 32'd0));
    dir_tab.push_back(mk(CMD_DELETE, 31'd1000, 32'd0));
    dir_tab.push_back(mk(CMD_DELETE, 31'd1000, 32'd0));
    dir_tab.push_back(mk(CMD_NONE, 31'h7fffffff, 32'hffffffff));
    dir_tab.push_back(mk(CMD_INSERT, 31'd999, 32'h12345678));
    dir_tab.push_back(mk(CMD_SEARCH, 31'd999, 32'd0));

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (dir_tab[i]) send_op(dir_tab[i]);

    for (int p = 0; p < 4; p++) begin
      send_idle_pct = (p == 1) ? 51 : (p == 3) ? 16 : 0;
      recv_stall_pct = (p == 2) ? 51 : (p == 3) ? 16 : 0;
      for (int i = 0; i < 30; i++) send_op(rand_op(40, 30));
    end

    // long receiver hold-off while beats keep coming
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_req++;
    for (int i = 0; i < 24; i++) send_op(rand_op(40, 30));

    // fill the pool, then run into pool full
    while (stored < NPOOL) begin
      op_row_t row;
      row = rand_op(100, 0);
      row.key = KEY_W'($urandom());
      send_op(row);
    end
    for (int i = 0; i < 8; i++) send_op(rand_op(100, 0));

    // sender pause until all results are back
    idle_input();
    wait (pending_q.size() == 0);

    send_idle_pct = 16;
    recv_stall_pct = 16;
    for (int i = 0; i < 40; i++) send_op(rand_op(20, 60));
    idle_input();

    wait (pending_q.size() == 0);
    repeat (200) @(posedge clk);
    if (fails == 0) $display("chained_hash_map_top: match");
    else $display("chained_hash_map_top: mismatch");
    $finish;
  end
endmodule

[filelist.f]
src/chm_pkg.sv
src/chm_mod.sv
src/chm_core.sv
src/chained_hash_map_top.sv
tb/tb.sv
